/* rtl/sacl_pkg.sv */
// Shared codes, widths and field types for the set-associative LRU cache simulator.
package sacl_pkg;

   // fixed field widths
   localparam int ADDR_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int CMD_W      = 2;
   localparam int OUTCOME_W  = 2;
   localparam int HITS_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [OUTCOME_W-1:0] outcome_type;
   typedef logic [HITS_W-1:0]    hits_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // access kinds
   localparam cmd_type CMD_LOAD   = 2'd0;
   localparam cmd_type CMD_STORE  = 2'd1;
   localparam cmd_type CMD_MODIFY = 2'd2;

   // lookup outcomes
   localparam outcome_type OUTCOME_HIT   = 2'd0;
   localparam outcome_type OUTCOME_FILL  = 2'd1;
   localparam outcome_type OUTCOME_EVICT = 2'd2;

   // control register indexes
   localparam csr_idx_type CSR_SET_BITS    = 2'd0;
   localparam csr_idx_type CSR_BLOCK_BITS  = 2'd1;
   localparam csr_idx_type CSR_WAYS_IN_USE = 2'd2;

endpackage

/* rtl/sacl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/set_assoc_cache_lru_sim_top.sv */
// Set-associative cache simulator with LRU replacement: set store, lookup and totals.
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+--------------------------------------
//  request   | req_cmd, req_address                | start high while busy low
//  response  | rsp_outcome, rsp_hits_added, totals | rsp_strobe high for one cycle
//  control   | csr_index, csr_wdata                | csr_wr_en high, written at once
//
// Each transaction reads its set row from the set store in the accept cycle, then
// compares, updates and writes it back in the lookup cycle; the next transaction
// may be accepted in the cycle the response is shown.
// The response is registered from the lookup state and cannot be stalled.
// After reset a clearing pass zeroes every row of the set store; busy stays high
// meanwhile, control writes are taken as ever.
module set_assoc_cache_lru_sim_top import sacl_pkg::*; #(
   parameter int SET_COUNT = 64,
   parameter int WAY_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [ADDR_W-1:0]     req_address,
   output logic                  rsp_strobe,
   output logic [OUTCOME_W-1:0]  rsp_outcome,
   output logic [HITS_W-1:0]     rsp_hits_added,
   output logic [COUNT_W-1:0]    rsp_hit_total,
   output logic [COUNT_W-1:0]    rsp_miss_total,
   output logic [COUNT_W-1:0]    rsp_eviction_total,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam int WAY_W    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam int LINE_W   = 1 + WAY_W + ADDR_W;
   localparam int ROW_W    = WAY_COUNT * LINE_W;
   localparam int RAW_SETS = 128;
   localparam logic [WAY_W-1:0] RANK_MAX  = WAY_W'(WAY_COUNT - 1);
   localparam logic [4:0]       WAY_LIMIT = 5'(WAY_COUNT);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]          set_bits_ff;
   logic [5:0]          block_bits_ff;
   logic [3:0]          ways_in_use_ff;
   logic [SET_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]   above_ff;
   logic [SET_W-1:0]    set_ff;
   cmd_type             cmd_ff;
   count_type           hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic                rsp_strobe_ff;
   outcome_type         outcome_ff;
   hits_type            hits_ff;

   logic                accept;
   logic                lookup;
   logic [ADDR_W-1:0]   above;
   logic [6:0]          set_raw;
   logic [SET_W-1:0]    set_mod [RAW_SETS];
   logic [SET_W-1:0]    set_idx;

   logic                ram_wr_en;
   logic [SET_W-1:0]    ram_wr_addr;
   logic [ROW_W-1:0]    ram_wr_data;
   logic [ROW_W-1:0]    ram_rd_data;

   logic [ADDR_W-1:0]   lookup_tag;
   logic [4:0]          eff_ways;
   logic [WAY_COUNT-1:0] way_valid, way_use, hit_vec, free_vec, max_vec;
   logic [WAY_W-1:0]    way_rank [WAY_COUNT];
   logic [ADDR_W-1:0]   way_tag  [WAY_COUNT];
   logic [WAY_W-1:0]    hit_idx, free_idx, vic_idx, tgt_idx, lim_rank;
   logic                is_hit, is_free, fill_case;
   logic [ROW_W-1:0]    new_row;
   outcome_type         outcome;
   hits_type            hits;
   logic [COUNT_W:0]    hit_sum, miss_sum, evict_sum;

   // set index reduction table: raw index modulo SET_COUNT
   for (genvar g = 0; g < RAW_SETS; g++) begin : g_set_mod
      localparam int REM = g % SET_COUNT;
      assign set_mod[g] = SET_W'(REM);
   end

   // request side address split
   assign accept  = start && (state_ff == ST_IDLE);
   assign lookup  = (state_ff == ST_LOOKUP);
   assign above   = req_address >> block_bits_ff;
   assign set_raw = above[6:0] & ~(7'h7F << set_bits_ff);
   assign set_idx = set_mod[set_raw];

   // set store: one row per set, each way {valid, rank, tag}
   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SET_COUNT)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (set_idx),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en   = (state_ff == ST_CLEAR) || lookup;
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : set_ff;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : new_row;

   // effective way count: zero reads as one, capped at WAY_COUNT
   always_comb begin
      eff_ways = (ways_in_use_ff == 4'd0) ? 5'd1 : {1'b0, ways_in_use_ff};
      if (eff_ways > WAY_LIMIT) begin
         eff_ways = WAY_LIMIT;
      end
   end

   assign lookup_tag = above_ff >> set_bits_ff;

   // unpack row, tag compare and free-way detect
   always_comb begin
      for (int i = 0; i < WAY_COUNT; i++) begin
         way_tag[i]   = ram_rd_data[i*LINE_W +: ADDR_W];
         way_rank[i]  = ram_rd_data[i*LINE_W + ADDR_W +: WAY_W];
         way_valid[i] = ram_rd_data[i*LINE_W + ADDR_W + WAY_W];
         way_use[i]   = (5'(i) < eff_ways);
         hit_vec[i]   = way_use[i] && way_valid[i] && (way_tag[i] == lookup_tag);
         free_vec[i]  = way_use[i] && !way_valid[i];
      end
   end

   // victim candidates: highest rank, lowest way wins a tie
   always_comb begin
      for (int i = 0; i < WAY_COUNT; i++) begin
         max_vec[i] = way_use[i];
         for (int j = 0; j < WAY_COUNT; j++) begin
            if (j < i && way_use[j] && way_rank[j] >= way_rank[i]) begin
               max_vec[i] = 1'b0;
            end
            if (j > i && way_use[j] && way_rank[j] > way_rank[i]) begin
               max_vec[i] = 1'b0;
            end
         end
      end
   end

   // first-set priority picks and target selection
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      vic_idx  = '0;
      for (int i = WAY_COUNT - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = WAY_W'(i);
         end
         if (free_vec[i]) begin
            free_idx = WAY_W'(i);
         end
         if (max_vec[i]) begin
            vic_idx = WAY_W'(i);
         end
      end
      is_hit    = |hit_vec;
      is_free   = |free_vec;
      fill_case = !is_hit && is_free;
      if (is_hit) begin
         tgt_idx  = hit_idx;
         lim_rank = way_rank[hit_idx];
         outcome  = OUTCOME_HIT;
      end else if (is_free) begin
         tgt_idx  = free_idx;
         lim_rank = RANK_MAX;
         outcome  = OUTCOME_FILL;
      end else begin
         tgt_idx  = vic_idx;
         lim_rank = way_rank[vic_idx];
         outcome  = OUTCOME_EVICT;
      end
      hits = HITS_W'(is_hit) + HITS_W'(cmd_ff == CMD_MODIFY);
   end

   // row update: target becomes newest, younger valid lines age by one
   always_comb begin
      new_row = ram_rd_data;
      for (int i = 0; i < WAY_COUNT; i++) begin
         if (way_use[i]) begin
            if (WAY_W'(i) == tgt_idx) begin
               new_row[i*LINE_W + ADDR_W + WAY_W] = 1'b1;
               new_row[i*LINE_W + ADDR_W +: WAY_W] = '0;
               if (!is_hit) begin
                  new_row[i*LINE_W +: ADDR_W] = lookup_tag;
               end
            end else if (way_valid[i] && (fill_case || way_rank[i] < lim_rank) &&
                         way_rank[i] < RANK_MAX) begin
               new_row[i*LINE_W + ADDR_W +: WAY_W] = way_rank[i] + WAY_W'(1);
            end
         end
      end
   end

   // saturating totals
   assign hit_sum   = {1'b0, hit_cnt_ff} + (COUNT_W+1)'(hits);
   assign miss_sum  = {1'b0, miss_cnt_ff} + (COUNT_W+1)'(outcome != OUTCOME_HIT);
   assign evict_sum = {1'b0, evict_cnt_ff} + (COUNT_W+1)'(outcome == OUTCOME_EVICT);

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // control state, totals and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_strobe_ff  <= 1'b0;
         hit_cnt_ff     <= '0;
         miss_cnt_ff    <= '0;
         evict_cnt_ff   <= '0;
         set_bits_ff    <= 3'd0;
         block_bits_ff  <= 6'd0;
         ways_in_use_ff <= 4'd1;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= lookup;
         if (lookup) begin
            hit_cnt_ff   <= hit_sum[COUNT_W] ? '1 : hit_sum[COUNT_W-1:0];
            miss_cnt_ff  <= miss_sum[COUNT_W] ? '1 : miss_sum[COUNT_W-1:0];
            evict_cnt_ff <= evict_sum[COUNT_W] ? '1 : evict_sum[COUNT_W-1:0];
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SET_BITS:    set_bits_ff    <= csr_wdata[2:0];
               CSR_BLOCK_BITS:  block_bits_ff  <= csr_wdata;
               CSR_WAYS_IN_USE: ways_in_use_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff <= above;
         set_ff   <= set_idx;
         cmd_ff   <= req_cmd;
      end
      if (lookup) begin
         outcome_ff <= outcome;
         hits_ff    <= hits;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_hits_added     = hits_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

endmodule

/* rtl/sacl_chk.sv */
// Port-level checker for the cache simulator top, bound to it below.
module sacl_chk import sacl_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input logic [OUTCOME_W-1:0] rsp_outcome,
   input logic [HITS_W-1:0]    rsp_hits_added,
   input logic [COUNT_W-1:0]   rsp_hit_total,
   input logic [COUNT_W-1:0]   rsp_miss_total,
   input logic [COUNT_W-1:0]   rsp_eviction_total
);

   logic accept;
   assign accept = start && !busy;

   // an accepted transaction locks out the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted transaction");

   // a response strobe follows each acceptance
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("response missing two cycles after acceptance");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // a hit always credits at least one hit
   a_hit_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_outcome == OUTCOME_HIT) |-> (rsp_hits_added != '0))
      else $error("hit reported without hit credit");

   // totals move only with a response
   a_totals_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe && !$past(reset) |->
         $stable(rsp_hit_total) && $stable(rsp_miss_total) && $stable(rsp_eviction_total))
      else $error("totals changed without a response");

endmodule

bind set_assoc_cache_lru_sim_top sacl_chk u_sacl_chk (.*);
